// File: sv/multi_board_timestamp_aligner_defines.svh
// assertion macros shared by the timestamp aligner modules
`ifndef MULTI_BOARD_TIMESTAMP_ALIGNER_DEFINES_SVH
`define MULTI_BOARD_TIMESTAMP_ALIGNER_DEFINES_SVH

`ifndef SYNTH
`define MBTA_ASSERT_IMPL(label, clk, rst, lhs, rhs) \
   label: assert property (@(posedge clk) disable iff (rst) (lhs) |-> (rhs)) \
      else $error("same-cycle check failed");
`define MBTA_ASSERT_NEXT(label, clk, rst, lhs, rhs) \
   label: assert property (@(posedge clk) disable iff (rst) (lhs) |=> (rhs)) \
      else $error("next-cycle check failed");
`else
`define MBTA_ASSERT_IMPL(label, clk, rst, lhs, rhs)
`define MBTA_ASSERT_NEXT(label, clk, rst, lhs, rhs)
`endif

`endif

// File: sv/mbta_pkg.sv
// shared constants and codes for the timestamp aligner
package mbta_pkg;

   localparam int DEFAULT_MAX_BOARDS = 8;
   localparam int DEFAULT_TIME_BITS  = 31;

   localparam int BOARD_BITS     = 3;
   localparam int RAW_BITS       = 32;
   localparam int COUNT_BITS     = 32;
   localparam int KIND_BITS      = 2;
   localparam int CFG_COUNT_BITS = 4;
   localparam int SKIP_BITS      = 16;
   localparam int CSR_IDX_BITS   = 4;
   localparam int CSR_DATA_BITS  = 32;

   localparam logic [KIND_BITS-1:0] KIND_ALIGNED = 2'd0;
   localparam logic [KIND_BITS-1:0] KIND_SKIP    = 2'd1;
   localparam logic [KIND_BITS-1:0] KIND_END     = 2'd2;

   localparam logic [CSR_IDX_BITS-1:0] CSR_BOARD_COUNT  = 4'd0;
   localparam logic [CSR_IDX_BITS-1:0] CSR_ALIGN_ENABLE = 4'd1;
   localparam logic [CSR_IDX_BITS-1:0] CSR_TOLERANCE    = 4'd2;
   localparam logic [CSR_IDX_BITS-1:0] CSR_INITIAL_SKIP = 4'd3;

   localparam logic [CFG_COUNT_BITS-1:0] RST_BOARD_COUNT = 4'd1;
   localparam logic                      RST_ALIGN_ENABLE = 1'b1;
   localparam int                        RST_TOLERANCE    = 256;

endpackage

// File: sv/multi_board_timestamp_aligner.sv
// top level of the multi-board timestamp aligner
// Events enter through a two-entry command queue; the front classifies each one in the
// cycle it is taken (ignored, skipped, end of run or new head), so the input stalls only
// when that queue is full. The back takes a command while idle, then checks whether every
// active board holds a head before it takes the next. Once all do, the back walks the n
// active boards one per cycle: one pass forms elapsed times and the largest, a second
// pass (alignment on) marks lagging boards, and a third pass emits into a two-entry result
// queue one result per board, or only the marked ones if any lags, holding while it is full.
// An end-of-run event yields a single result; all later events are taken and dropped,
// unless a config write is taken with it. No clearing pass runs after reset.
module multi_board_timestamp_aligner #(
   parameter int MAX_BOARDS = mbta_pkg::DEFAULT_MAX_BOARDS,
   parameter int TIME_BITS  = mbta_pkg::DEFAULT_TIME_BITS
) (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               req_push,
   output logic                               req_full,
   input  logic [mbta_pkg::BOARD_BITS-1:0]    req_board,
   input  logic [mbta_pkg::RAW_BITS-1:0]      req_raw_time,
   input  logic                               req_end_of_run,
   output logic                               rsp_empty,
   input  logic                               rsp_pop,
   output logic [mbta_pkg::KIND_BITS-1:0]     rsp_kind,
   output logic [mbta_pkg::BOARD_BITS-1:0]    rsp_board_index,
   output logic [TIME_BITS-1:0]               rsp_time_tag,
   output logic [TIME_BITS-1:0]               rsp_elapsed,
   output logic [mbta_pkg::COUNT_BITS-1:0]    rsp_event_count,
   output logic                               rsp_last,
   input  logic                               csr_valid,
   output logic                               csr_ready,
   input  logic [mbta_pkg::CSR_IDX_BITS-1:0]  csr_index,
   input  logic [mbta_pkg::CSR_DATA_BITS-1:0] csr_data
);
   import mbta_pkg::*;

   localparam int CNT_W = $clog2(MAX_BOARDS + 1);
   localparam int CMD_W = TIME_BITS + BOARD_BITS + 1;
   localparam int RSP_W = 2 * TIME_BITS + KIND_BITS + BOARD_BITS + COUNT_BITS + 1;

   logic             fq_push, fq_full, fq_pop, fq_empty;
   logic [CMD_W-1:0] fq_in_data, fq_out_data;
   logic [CNT_W-1:0] active_count;
   logic             align_en;
   logic [TIME_BITS-1:0] tolerance;
   logic             rq_push, rq_full;
   logic [RSP_W-1:0] rq_in_data, rq_out_data;

   mbta_front #(
      .MAX_BOARDS(MAX_BOARDS),
      .TIME_BITS (TIME_BITS)
   ) u_front (
      .clock         (clock),
      .reset         (reset),
      .req_push      (req_push),
      .req_full      (req_full),
      .req_board     (req_board),
      .req_raw_time  (req_raw_time),
      .req_end_of_run(req_end_of_run),
      .csr_valid     (csr_valid),
      .csr_ready     (csr_ready),
      .csr_index     (csr_index),
      .csr_data      (csr_data),
      .cmd_push      (fq_push),
      .cmd_data      (fq_in_data),
      .cmd_full      (fq_full),
      .active_count  (active_count),
      .align_en      (align_en),
      .tolerance     (tolerance)
   );

   mbta_fifo #(
      .WIDTH(CMD_W),
      .DEPTH(2)
   ) u_cmd_queue (
      .clock    (clock),
      .reset    (reset),
      .push     (fq_push),
      .push_data(fq_in_data),
      .full     (fq_full),
      .pop      (fq_pop),
      .pop_data (fq_out_data),
      .empty    (fq_empty)
   );

   mbta_back #(
      .MAX_BOARDS(MAX_BOARDS),
      .TIME_BITS (TIME_BITS)
   ) u_back (
      .clock       (clock),
      .reset       (reset),
      .cmd_empty   (fq_empty),
      .cmd_pop     (fq_pop),
      .cmd_data    (fq_out_data),
      .active_count(active_count),
      .align_en    (align_en),
      .tolerance   (tolerance),
      .rsp_full    (rq_full),
      .rsp_push    (rq_push),
      .rsp_data    (rq_in_data)
   );

   mbta_fifo #(
      .WIDTH(RSP_W),
      .DEPTH(2)
   ) u_rsp_queue (
      .clock    (clock),
      .reset    (reset),
      .push     (rq_push),
      .push_data(rq_in_data),
      .full     (rq_full),
      .pop      (rsp_pop),
      .pop_data (rq_out_data),
      .empty    (rsp_empty)
   );

   assign {rsp_kind, rsp_board_index, rsp_time_tag, rsp_elapsed,
           rsp_event_count, rsp_last} = rq_out_data;

endmodule

// File: sv/mbta_fifo.sv
// small register queue with push/pop handshake
module mbta_fifo #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 2
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             push,
   input  logic [WIDTH-1:0] push_data,
   output logic             full,
   input  logic             pop,
   output logic [WIDTH-1:0] pop_data,
   output logic             empty
);

   localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CNT_W = $clog2(DEPTH + 1);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [PTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0] count_ff, count_in;
   logic             do_push, do_pop;

   assign full     = (count_ff == CNT_W'(DEPTH));
   assign empty    = (count_ff == '0);
   assign do_push  = push && !full;
   assign do_pop   = pop && !empty;
   assign pop_data = mem_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_ff + PTR_W'(1);
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_ff + PTR_W'(1);
      end
      if (do_push && !do_pop) begin
         count_in = count_ff + CNT_W'(1);
      end else if (do_pop && !do_push) begin
         count_in = count_ff - CNT_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         mem_ff[wr_ptr_ff] <= push_data;
      end
   end

endmodule

// File: sv/mbta_front.sv
// input side: config registers, event classification, initial skip counters
module mbta_front #(
   parameter int MAX_BOARDS = mbta_pkg::DEFAULT_MAX_BOARDS,
   parameter int TIME_BITS  = mbta_pkg::DEFAULT_TIME_BITS
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_push,
   output logic                                req_full,
   input  logic [mbta_pkg::BOARD_BITS-1:0]     req_board,
   input  logic [mbta_pkg::RAW_BITS-1:0]       req_raw_time,
   input  logic                                req_end_of_run,
   input  logic                                csr_valid,
   output logic                                csr_ready,
   input  logic [mbta_pkg::CSR_IDX_BITS-1:0]   csr_index,
   input  logic [mbta_pkg::CSR_DATA_BITS-1:0]  csr_data,
   output logic                                cmd_push,
   output logic [TIME_BITS+mbta_pkg::BOARD_BITS:0] cmd_data,
   input  logic                                cmd_full,
   output logic [$clog2(MAX_BOARDS+1)-1:0]     active_count,
   output logic                                align_en,
   output logic [TIME_BITS-1:0]                tolerance
);
   import mbta_pkg::*;

   localparam int IDX_W = (MAX_BOARDS > 1) ? $clog2(MAX_BOARDS) : 1;
   localparam int CNT_W = $clog2(MAX_BOARDS + 1);

   logic [CFG_COUNT_BITS-1:0] board_count_ff, board_count_in;
   logic                      align_ff, align_in;
   logic [TIME_BITS-1:0]      tol_ff, tol_in;
   logic [SKIP_BITS-1:0]      skip_left_ff [MAX_BOARDS];
   logic [SKIP_BITS-1:0]      skip_left_in [MAX_BOARDS];
   logic                      run_over_ff, run_over_in;

   logic             req_fire, csr_fire;
   logic [IDX_W-1:0] idx;
   logic             inactive, skip_hit, live;
   logic [31:0]      n_wide;

   assign csr_ready = 1'b1;
   assign csr_fire  = csr_valid && csr_ready;
   assign req_full  = cmd_full;
   assign req_fire  = req_push && !cmd_full;

   always_comb begin
      if (board_count_ff == '0) begin
         n_wide = 32'd1;
      end else if (32'(board_count_ff) > 32'(MAX_BOARDS)) begin
         n_wide = 32'(MAX_BOARDS);
      end else begin
         n_wide = 32'(board_count_ff);
      end
   end

   assign active_count = CNT_W'(n_wide);
   assign align_en     = align_ff;
   assign tolerance    = tol_ff;

   assign idx      = IDX_W'(req_board);
   assign inactive = 32'(req_board) >= n_wide;
   assign skip_hit = (req_board != '0) && (skip_left_ff[idx] != '0);
   assign live     = req_fire && !run_over_ff && !inactive;
   assign cmd_push = live && (req_end_of_run || !skip_hit);
   assign cmd_data = {req_end_of_run, req_board, TIME_BITS'(req_raw_time)};

   always_comb begin
      board_count_in = board_count_ff;
      align_in       = align_ff;
      tol_in         = tol_ff;
      run_over_in    = run_over_ff;
      skip_left_in   = skip_left_ff;
      if (csr_fire) begin
         case (csr_index)
            CSR_BOARD_COUNT:  board_count_in = csr_data[CFG_COUNT_BITS-1:0];
            CSR_ALIGN_ENABLE: align_in = csr_data[0];
            CSR_TOLERANCE:    tol_in = TIME_BITS'(csr_data);
            CSR_INITIAL_SKIP: begin
               for (int b = 1; b < MAX_BOARDS; b++) begin
                  skip_left_in[b] = csr_data[SKIP_BITS-1:0];
               end
            end
            default: ;
         endcase
      end else if (live) begin
         if (req_end_of_run) begin
            run_over_in = 1'b1;
         end else if (skip_hit) begin
            skip_left_in[idx] = skip_left_ff[idx] - SKIP_BITS'(1);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         board_count_ff <= RST_BOARD_COUNT;
         align_ff       <= RST_ALIGN_ENABLE;
         tol_ff         <= TIME_BITS'(RST_TOLERANCE);
         run_over_ff    <= 1'b0;
         for (int b = 0; b < MAX_BOARDS; b++) begin
            skip_left_ff[b] <= '0;
         end
      end else begin
         board_count_ff <= board_count_in;
         align_ff       <= align_in;
         tol_ff         <= tol_in;
         run_over_ff    <= run_over_in;
         skip_left_ff   <= skip_left_in;
      end
   end

`include "multi_board_timestamp_aligner_defines.svh"

   `MBTA_ASSERT_IMPL(a_no_cmd_after_end, clock, reset, run_over_ff, !cmd_push)
   `MBTA_ASSERT_IMPL(a_skip_drops_event, clock, reset, live && !req_end_of_run && skip_hit, !cmd_push)
   `MBTA_ASSERT_NEXT(a_end_latches, clock, reset, live && req_end_of_run && !csr_fire, run_over_ff)

endmodule

// File: sv/mbta_back.sv
// evaluation side: head store, board walk for elapsed, max, skip, aligned and end-of-run results
module mbta_back #(
   parameter int MAX_BOARDS = mbta_pkg::DEFAULT_MAX_BOARDS,
   parameter int TIME_BITS  = mbta_pkg::DEFAULT_TIME_BITS
) (
   input  logic                                    clock,
   input  logic                                    reset,
   input  logic                                    cmd_empty,
   output logic                                    cmd_pop,
   input  logic [TIME_BITS+mbta_pkg::BOARD_BITS:0] cmd_data,
   input  logic [$clog2(MAX_BOARDS+1)-1:0]         active_count,
   input  logic                                    align_en,
   input  logic [TIME_BITS-1:0]                    tolerance,
   input  logic                                    rsp_full,
   output logic                                    rsp_push,
   output logic [2*TIME_BITS+mbta_pkg::KIND_BITS+mbta_pkg::BOARD_BITS
                 +mbta_pkg::COUNT_BITS:0]          rsp_data
);
   import mbta_pkg::*;

   localparam int IDX_W = (MAX_BOARDS > 1) ? $clog2(MAX_BOARDS) : 1;
   localparam int CNT_W = $clog2(MAX_BOARDS + 1);
   localparam int CMD_W = TIME_BITS + BOARD_BITS + 1;

   localparam logic [2:0] ST_IDLE  = 3'd0;
   localparam logic [2:0] ST_CHECK = 3'd1;
   localparam logic [2:0] ST_SCAN  = 3'd2;
   localparam logic [2:0] ST_MARK  = 3'd3;
   localparam logic [2:0] ST_EMIT  = 3'd4;
   localparam logic [2:0] ST_END   = 3'd5;

   logic [2:0]            state_ff, state_in;
   logic [CNT_W-1:0]      walk_ff, walk_in;
   logic [TIME_BITS-1:0]  head_time_ff [MAX_BOARDS];
   logic [TIME_BITS-1:0]  head_time_in [MAX_BOARDS];
   logic [TIME_BITS-1:0]  good_time_ff [MAX_BOARDS];
   logic [TIME_BITS-1:0]  good_time_in [MAX_BOARDS];
   logic [MAX_BOARDS-1:0] head_valid_ff, head_valid_in;
   logic [MAX_BOARDS-1:0] skip_mask_ff, skip_mask_in;
   logic                  skip_mode_ff, skip_mode_in;
   logic [TIME_BITS-1:0]  max_ff, max_in;
   logic [COUNT_BITS-1:0] aligned_ff, aligned_in;
   logic [BOARD_BITS-1:0] end_board_ff, end_board_in;

   logic                  cmd_end;
   logic [BOARD_BITS-1:0] cmd_board;
   logic [TIME_BITS-1:0]  cmd_time;
   logic [IDX_W-1:0]      idx;
   logic                  walk_last, first_set, all_valid, hit, skip_last;
   logic [TIME_BITS-1:0]  cur_head, cur_el, scan_el;
   logic [MAX_BOARDS-1:0] active_mask, upper_mask;

   logic [KIND_BITS-1:0]  res_kind;
   logic [BOARD_BITS-1:0] res_board;
   logic [TIME_BITS-1:0]  res_time, res_el;
   logic                  res_last;

   assign cmd_end   = cmd_data[CMD_W-1];
   assign cmd_board = cmd_data[CMD_W-2 -: BOARD_BITS];
   assign cmd_time  = cmd_data[TIME_BITS-1:0];

   assign idx       = walk_ff[IDX_W-1:0];
   assign walk_last = (walk_ff == active_count - CNT_W'(1));
   assign first_set = (aligned_ff == '0);
   assign cur_head  = head_time_ff[idx];
   assign cur_el    = cur_head - good_time_ff[idx];
   assign scan_el   = first_set ? '0 : cur_el;
   assign hit       = (max_ff - cur_el) >= tolerance;

   always_comb begin
      for (int j = 0; j < MAX_BOARDS; j++) begin
         active_mask[j] = 32'(j) < 32'(active_count);
         upper_mask[j]  = j > int'(idx);
      end
   end

   assign all_valid = &(head_valid_ff | ~active_mask);
   assign skip_last = (skip_mask_ff & upper_mask) == '0;

   always_comb begin
      state_in      = state_ff;
      walk_in       = walk_ff;
      head_time_in  = head_time_ff;
      good_time_in  = good_time_ff;
      head_valid_in = head_valid_ff;
      skip_mask_in  = skip_mask_ff;
      skip_mode_in  = skip_mode_ff;
      max_in        = max_ff;
      aligned_in    = aligned_ff;
      end_board_in  = end_board_ff;
      cmd_pop       = 1'b0;
      rsp_push      = 1'b0;
      res_kind      = KIND_ALIGNED;
      res_board     = BOARD_BITS'(walk_ff);
      res_time      = cur_head;
      res_el        = cur_el;
      res_last      = walk_last;
      case (state_ff)
         ST_IDLE: begin
            if (!cmd_empty) begin
               cmd_pop = 1'b1;
               if (cmd_end) begin
                  end_board_in = cmd_board;
                  state_in     = ST_END;
               end else begin
                  head_time_in[IDX_W'(cmd_board)]  = cmd_time;
                  head_valid_in[IDX_W'(cmd_board)] = 1'b1;
                  state_in = ST_CHECK;
               end
            end
         end
         ST_CHECK: begin
            walk_in  = '0;
            max_in   = '0;
            state_in = all_valid ? ST_SCAN : ST_IDLE;
         end
         ST_SCAN: begin
            if (first_set) begin
               good_time_in[idx] = cur_head;
            end
            if (scan_el > max_ff) begin
               max_in = scan_el;
            end
            walk_in = walk_ff + CNT_W'(1);
            if (walk_last) begin
               walk_in      = '0;
               skip_mask_in = '0;
               skip_mode_in = 1'b0;
               state_in     = align_en ? ST_MARK : ST_EMIT;
            end
         end
         ST_MARK: begin
            skip_mask_in[idx] = hit;
            walk_in = walk_ff + CNT_W'(1);
            if (walk_last) begin
               walk_in      = '0;
               skip_mode_in = (skip_mask_ff != '0) || hit;
               state_in     = ST_EMIT;
            end
         end
         ST_EMIT: begin
            if (skip_mode_ff) begin
               res_kind = KIND_SKIP;
               res_last = skip_last;
               if (skip_mask_ff[idx]) begin
                  rsp_push = !rsp_full;
               end
               if (!skip_mask_ff[idx] || !rsp_full) begin
                  if (skip_mask_ff[idx]) begin
                     head_valid_in[idx] = 1'b0;
                  end
                  walk_in = walk_ff + CNT_W'(1);
                  if (walk_last) begin
                     state_in = ST_IDLE;
                  end
               end
            end else begin
               rsp_push = !rsp_full;
               if (!rsp_full) begin
                  good_time_in[idx]  = cur_head;
                  head_valid_in[idx] = 1'b0;
                  walk_in = walk_ff + CNT_W'(1);
                  if (walk_last) begin
                     aligned_in = aligned_ff + COUNT_BITS'(1);
                     state_in   = ST_IDLE;
                  end
               end
            end
         end
         ST_END: begin
            res_kind  = KIND_END;
            res_board = end_board_ff;
            res_time  = '0;
            res_el    = '0;
            res_last  = 1'b1;
            rsp_push  = !rsp_full;
            if (!rsp_full) begin
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   assign rsp_data = {res_kind, res_board, res_time, res_el, aligned_ff, res_last};

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_IDLE;
         walk_ff       <= '0;
         head_valid_ff <= '0;
         skip_mask_ff  <= '0;
         skip_mode_ff  <= 1'b0;
         aligned_ff    <= '0;
      end else begin
         state_ff      <= state_in;
         walk_ff       <= walk_in;
         head_valid_ff <= head_valid_in;
         skip_mask_ff  <= skip_mask_in;
         skip_mode_ff  <= skip_mode_in;
         aligned_ff    <= aligned_in;
      end
   end

   always_ff @(posedge clock) begin
      head_time_ff <= head_time_in;
      good_time_ff <= good_time_in;
      max_ff       <= max_in;
      end_board_ff <= end_board_in;
   end

`include "multi_board_timestamp_aligner_defines.svh"

   `MBTA_ASSERT_IMPL(a_scan_needs_heads, clock, reset, state_ff == ST_SCAN, all_valid)
   `MBTA_ASSERT_IMPL(a_push_in_output_state, clock, reset, rsp_push, state_ff == ST_EMIT || state_ff == ST_END)
   `MBTA_ASSERT_NEXT(a_count_steady, clock, reset, !(rsp_push && res_last && res_kind == KIND_ALIGNED), $stable(aligned_ff))

endmodule

// File: tb/testbench.sv
`timescale 1ns / 1ps
// testbench for the multi-board timestamp aligner: directed and random event sets
module testbench;
   import mbta_pkg::*;

   localparam int NB = DEFAULT_MAX_BOARDS;
   localparam int TW = DEFAULT_TIME_BITS;
   localparam int SETTLE_CYCLES = 100;
   localparam int MAX_REPORTS = 10;
   localparam bit [TW-1:0] TIME_MAX = '1;

   typedef struct {
      logic [KIND_BITS-1:0]  kind;
      logic [BOARD_BITS-1:0] board;
      logic [TW-1:0]         time_tag;
      logic [TW-1:0]         elapsed;
      logic [COUNT_BITS-1:0] event_count;
      logic                  last;
   } board_result_type;

   logic                     clock = 1'b0;
   logic                     reset = 1'b1;
   logic                     req_push = 1'b0;
   logic                     req_full;
   logic [BOARD_BITS-1:0]    req_board = '0;
   logic [RAW_BITS-1:0]      req_raw_time = '0;
   logic                     req_end_of_run = 1'b0;
   logic                     rsp_empty;
   logic                     rsp_pop = 1'b0;
   logic [KIND_BITS-1:0]     rsp_kind;
   logic [BOARD_BITS-1:0]    rsp_board_index;
   logic [TW-1:0]            rsp_time_tag;
   logic [TW-1:0]            rsp_elapsed;
   logic [COUNT_BITS-1:0]    rsp_event_count;
   logic                     rsp_last;
   logic                     csr_valid = 1'b0;
   logic                     csr_ready;
   logic [CSR_IDX_BITS-1:0]  csr_index = '0;
   logic [CSR_DATA_BITS-1:0] csr_data = '0;

   // predicted state of the aligner
   bit [CFG_COUNT_BITS-1:0] board_limit = RST_BOARD_COUNT;
   bit                      align_on = RST_ALIGN_ENABLE;
   bit [TW-1:0]             tol_ticks = TW'(RST_TOLERANCE);
   bit [TW-1:0]             head_tag [NB];
   bit                      head_present [NB];
   bit [TW-1:0]             ref_tag [NB];
   bit [SKIP_BITS-1:0]      drop_left [NB];
   bit [COUNT_BITS-1:0]     set_count = '0;
   bit                      run_done = 1'b0;

   board_result_type pending_results [$];
   int mismatch_count = 0;
   int counted_items = 0;
   int send_idle_pct = 0;
   int recv_stall_pct = 0;

   multi_board_timestamp_aligner dut (
      .clock           (clock),
      .reset           (reset),
      .req_push        (req_push),
      .req_full        (req_full),
      .req_board       (req_board),
      .req_raw_time    (req_raw_time),
      .req_end_of_run  (req_end_of_run),
      .rsp_empty       (rsp_empty),
      .rsp_pop         (rsp_pop),
      .rsp_kind        (rsp_kind),
      .rsp_board_index (rsp_board_index),
      .rsp_time_tag    (rsp_time_tag),
      .rsp_elapsed     (rsp_elapsed),
      .rsp_event_count (rsp_event_count),
      .rsp_last        (rsp_last),
      .csr_valid       (csr_valid),
      .csr_ready       (csr_ready),
      .csr_index       (csr_index),
      .csr_data        (csr_data)
   );

   always #10 clock = ~clock;

   function automatic int active_count();
      if (board_limit == 0) return 1;
      if (board_limit > NB) return NB;
      return int'(board_limit);
   endfunction

   function automatic board_result_type make_result(input logic [KIND_BITS-1:0] kind,
                                                    input int b,
                                                    input bit [TW-1:0] tag,
                                                    input bit [TW-1:0] el,
                                                    input bit closing);
      board_result_type r;
      r.kind = kind;
      r.board = b[BOARD_BITS-1:0];
      r.time_tag = tag;
      r.elapsed = el;
      r.event_count = set_count;
      r.last = closing;
      return r;
   endfunction

   function automatic void queue_expected(input board_result_type r);
      pending_results = {pending_results, r};
   endfunction

   // works out the results of one accepted event
   task automatic compute_board_results(input logic [BOARD_BITS-1:0] b,
                                        input logic [RAW_BITS-1:0] raw, input logic eor);
      bit [TW-1:0] el [NB];
      int n;
      int lead;
      int final_skip;
      n = active_count();
      lead = 0;
      final_skip = -1;
      if (run_done || b >= n) return;
      if (eor) begin
         run_done = 1'b1;
         queue_expected(make_result(KIND_END, int'(b), '0, '0, 1'b1));
         return;
      end
      if (b != 0 && drop_left[b] != 0) begin
         drop_left[b]--;
         return;
      end
      head_tag[b] = raw[TW-1:0];
      head_present[b] = 1'b1;
      for (int i = 0; i < n; i++)
         if (!head_present[i]) return;
      for (int i = 0; i < n; i++) begin
         if (set_count == 0) ref_tag[i] = head_tag[i];
         el[i] = head_tag[i] - ref_tag[i];
         if (el[i] > el[lead]) lead = i;
      end
      if (align_on) begin
         for (int i = 0; i < n; i++)
            if (el[lead] - el[i] >= tol_ticks) final_skip = i;
         if (final_skip >= 0) begin
            for (int i = 0; i < n; i++) begin
               if (el[lead] - el[i] >= tol_ticks) begin
                  queue_expected(make_result(KIND_SKIP, i, head_tag[i], el[i],
                                             i == final_skip));
                  head_present[i] = 1'b0;
               end
            end
            return;
         end
      end
      for (int i = 0; i < n; i++) begin
         queue_expected(make_result(KIND_ALIGNED, i, head_tag[i], el[i], i == n - 1));
         ref_tag[i] = head_tag[i];
         head_present[i] = 1'b0;
      end
      set_count++;
   endtask

   task automatic push_event(input logic [BOARD_BITS-1:0] b, input logic [RAW_BITS-1:0] raw,
                             input logic eor);
      while ($urandom_range(99) < send_idle_pct) begin
         @(negedge clock);
         req_push = 1'b0;
      end
      @(negedge clock);
      req_push = 1'b1;
      req_board = b;
      req_raw_time = raw;
      req_end_of_run = eor;
      @(posedge clock);
      while (req_full) @(posedge clock);
      if (b < active_count()) counted_items++;
      compute_board_results(b, raw, eor);
   endtask

   task automatic wait_quiet();
      @(negedge clock);
      req_push = 1'b0;
      while (pending_results.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic write_csr(input logic [CSR_IDX_BITS-1:0] idx,
                            input logic [CSR_DATA_BITS-1:0] data);
      wait_quiet();
      @(negedge clock);
      csr_valid = 1'b1;
      csr_index = idx;
      csr_data = data;
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
      case (idx)
         CSR_BOARD_COUNT:  board_limit = data[CFG_COUNT_BITS-1:0];
         CSR_ALIGN_ENABLE: align_on = data[0];
         CSR_TOLERANCE:    tol_ticks = data[TW-1:0];
         CSR_INITIAL_SKIP: begin
            for (int i = 1; i < NB; i++) drop_left[i] = data[SKIP_BITS-1:0];
         end
         default: ;
      endcase
      @(negedge clock);
      csr_valid = 1'b0;
   endtask

   // one set: each board without a head, and at times one with a head, gets an event
   task automatic send_event_set();
      bit [COUNT_BITS-1:0] start_count;
      bit [TW-1:0] advance;
      bit [TW-1:0] jitter;
      bit [TW-1:0] tag;
      int n;
      int start;
      int b;
      int rounds;
      n = active_count();
      start_count = set_count;
      rounds = 0;
      case ($urandom_range(9))
         0:       advance = '0;
         1, 2:    advance = TW'($urandom());
         default: advance = TW'($urandom_range(1, 100000));
      endcase
      while (set_count == start_count && rounds < 5) begin
         start = int'($urandom_range(n - 1));
         for (int k = 0; k < n; k++) begin
            b = (start + k) % n;
            if (!head_present[b] || $urandom_range(15) == 0) begin
               case ($urandom_range(9))
                  0:          jitter = TW'($urandom());
                  1, 2, 3:    jitter = TW'($urandom_range(4095));
                  default:    jitter = TW'($urandom_range(63));
               endcase
               tag = ref_tag[b] + advance + jitter;
               push_event(BOARD_BITS'(b), {1'($urandom_range(1)), tag}, 1'b0);
            end
            if (set_count != start_count) break;
         end
         rounds++;
      end
   endtask

   always @(negedge clock) rsp_pop <= ($urandom_range(99) >= recv_stall_pct);

   always @(posedge clock) begin : check_results
      board_result_type want;
      if (!reset && rsp_pop && !rsp_empty) begin
         if (pending_results.size() == 0) begin
            mismatch_count++;
            if (mismatch_count <= MAX_REPORTS)
               $display("unexpected result: kind %0d board %0d tag %h elapsed %h",
                        rsp_kind, rsp_board_index, rsp_time_tag, rsp_elapsed);
         end else begin
            want = pending_results.pop_front();
            if (want.kind !== rsp_kind || want.board !== rsp_board_index ||
                want.time_tag !== rsp_time_tag || want.elapsed !== rsp_elapsed ||
                want.event_count !== rsp_event_count || want.last !== rsp_last) begin
               mismatch_count++;
               if (mismatch_count <= MAX_REPORTS) begin
                  $display("mismatch: expected kind %0d board %0d tag %h elapsed %h count %0d last %0b",
                           want.kind, want.board, want.time_tag, want.elapsed,
                           want.event_count, want.last);
                  $display("          actual   kind %0d board %0d tag %h elapsed %h count %0d last %0b",
                           rsp_kind, rsp_board_index, rsp_time_tag, rsp_elapsed,
                           rsp_event_count, rsp_last);
               end
            end
         end
      end
   end

   task automatic test_inactive_boards();
      push_event(3'd2, $urandom(), 1'b0);
      push_event(3'd7, 32'hFFFF_FFFF, 1'b0);
      push_event(3'd5, $urandom(), 1'b1);
   endtask

   // first set covers all eight boards so every good time is known from here on
   task automatic test_first_full_set();
      logic [RAW_BITS-1:0] raw [NB];
      raw[0] = 32'h0000_0000;
      raw[1] = 32'hFFFF_FFFF;
      raw[2] = 32'h8000_0000;
      raw[3] = 32'h7FFF_FFFF;
      for (int i = 4; i < NB; i++) raw[i] = $urandom();
      write_csr(CSR_BOARD_COUNT, 32'hFFFF_FFFF);
      push_event(3'd3, $urandom(), 1'b0);
      for (int i = NB - 1; i >= 0; i--) push_event(BOARD_BITS'(i), raw[i], 1'b0);
   endtask

   task automatic test_tolerance_limit();
      bit [TW-1:0] tag;
      write_csr(CSR_BOARD_COUNT, 32'd2);
      write_csr(CSR_TOLERANCE, 32'hFFFF_FFFF);
      tag = ref_tag[0] + TIME_MAX;
      push_event(3'd0, {1'b1, tag}, 1'b0);
      push_event(3'd1, {1'b0, ref_tag[1]}, 1'b0);
      tag = ref_tag[1] + TIME_MAX;
      push_event(3'd1, {1'b0, tag}, 1'b0);
   endtask

   task automatic test_zero_tolerance();
      bit [TW-1:0] tag;
      write_csr(CSR_BOARD_COUNT, 32'd0);
      write_csr(CSR_TOLERANCE, 32'd0);
      tag = ref_tag[0] + TW'(7);
      push_event(3'd0, {1'b0, tag}, 1'b0);
   endtask

   task automatic test_alignment_off();
      bit [TW-1:0] tag;
      write_csr(CSR_ALIGN_ENABLE, 32'hFFFF_FFFE);
      write_csr(CSR_BOARD_COUNT, 32'd3);
      tag = ref_tag[0] + TW'(5);
      push_event(3'd0, {1'b0, tag}, 1'b0);
      tag = ref_tag[1] + 31'h4000_0000;
      push_event(3'd1, {1'b1, tag}, 1'b0);
      push_event(3'd2, {1'b0, ref_tag[2]}, 1'b0);
      write_csr(CSR_ALIGN_ENABLE, 32'd1);
   endtask

   task automatic test_initial_skip();
      bit [TW-1:0] tag;
      write_csr(CSR_TOLERANCE, 32'd256);
      write_csr(CSR_INITIAL_SKIP, 32'd1);
      push_event(3'd1, $urandom(), 1'b0);
      push_event(3'd2, $urandom(), 1'b0);
      for (int i = 0; i < 3; i++) begin
         tag = ref_tag[i] + TW'(1000 + i);
         push_event(BOARD_BITS'(i), {1'b0, tag}, 1'b0);
      end
      write_csr(CSR_INITIAL_SKIP, 32'hA5C3_FFFF);
      push_event(3'd2, $urandom(), 1'b0);
      write_csr(CSR_INITIAL_SKIP, 32'd0);
   endtask

   task automatic test_random_sets(input int idle_pct, input int stall_pct);
      logic [CSR_DATA_BITS-1:0] word;
      logic [BOARD_BITS-1:0] b;
      int first;
      send_idle_pct = idle_pct;
      recv_stall_pct = stall_pct;
      repeat (2) begin
         word = $urandom();
         word[CFG_COUNT_BITS-1:0] = CFG_COUNT_BITS'($urandom_range(15));
         write_csr(CSR_BOARD_COUNT, word);
         write_csr(CSR_ALIGN_ENABLE, ($urandom_range(3) != 0) ? 32'd1 : 32'd0);
         case ($urandom_range(5))
            0:       word = 32'd0;
            1:       word = $urandom_range(1, 64);
            2:       word = 32'd256;
            3:       word = $urandom_range(1000, 5000);
            4:       word = {1'($urandom_range(1)), TIME_MAX};
            default: word = $urandom();
         endcase
         write_csr(CSR_TOLERANCE, word);
         word = $urandom();
         word[SKIP_BITS-1:0] = ($urandom_range(3) == 0) ?
                               SKIP_BITS'($urandom_range(1, 3)) : '0;
         write_csr(CSR_INITIAL_SKIP, word);
         first = counted_items;
         while (counted_items - first < 32) begin
            if ($urandom_range(4) == 0) begin
               b = BOARD_BITS'($urandom_range(NB - 1));
               push_event(b, $urandom(), b >= active_count() && $urandom_range(3) == 0);
            end else begin
               send_event_set();
            end
            if ($urandom_range(30) == 0) wait_quiet();
         end
      end
   endtask

   task automatic test_end_of_run();
      push_event(BOARD_BITS'($urandom_range(active_count() - 1)), $urandom(), 1'b1);
      push_event(3'd0, $urandom(), 1'b0);
      push_event(3'd0, $urandom(), 1'b1);
      push_event(BOARD_BITS'($urandom_range(NB - 1)), $urandom(), 1'b0);
   endtask

   initial begin
      repeat (9) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;
      test_inactive_boards();
      test_first_full_set();
      test_tolerance_limit();
      test_zero_tolerance();
      test_alignment_off();
      test_initial_skip();
      test_random_sets(0, 0);
      test_random_sets(49, 0);
      test_random_sets(0, 49);
      test_random_sets(36, 36);
      test_end_of_run();
      wait_quiet();
      if (mismatch_count == 0 && pending_results.size() == 0)
         $display("PASSED: all results match");
      else
         $display("FAILED: results differ");
      $finish;
   end

   initial begin
      #10_000_000;
      $display("FAILED: results differ");
      $finish;
   end

endmodule
